// File: rtl/core/gsf_pkg.sv
`default_nettype none

package gsf_pkg;

    typedef enum logic [2:0] {
        CLS_CONTROL,
        CLS_GRAPHIC,
        CLS_DIGIT,
        CLS_TRAIL,
        CLS_LEAD,
        CLS_INVALID
    } t_cls;

    typedef enum logic [1:0] {
        RK_SINGLE    = 2'd0,
        RK_TWO       = 2'd1,
        RK_FOUR      = 2'd2,
        RK_MALFORMED = 2'd3
    } t_rkind;

    // phase equals the number of pending bytes
    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2,
        PH_THREE = 2'd3
    } t_phase;

    localparam logic [7:0] ZONE_MIN = 8'hA1;

    typedef struct packed {
        logic        valid;
        t_rkind      kind;
        logic [31:0] code;
        logic [2:0]  count;
        logic        zone;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/gb18030_sequence_framer.sv
`default_nettype none

// Channel  Dir  tdata (low bit up)                     tuser (low bit up)
// s        in   [7:0] byte_value                       [0] kind (1 = flush)
// m        out  [31:0] code_bytes, [34:32] byte_count  [1:0] result_kind,
//               [39:35] zero                           [2] gb2312_zone
//
// One request per cycle sustained while the output is not stalled; each
// byte is held in the input register, and any result it closes is written
// to the output register on the edge at which the byte leaves it.
// Reset (synchronous, active low) clears the phase and both valid flags.
// A stalled output holds the result; the input side keeps taking requests
// until the input register is also full.
module gb18030_sequence_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  i_s_tuser,   // [0] kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [31:0] code_bytes, [34:32] byte_count
    output logic [2:0]       o_m_tuser    // [1:0] result_kind, [2] gb2312_zone
);
    import gsf_pkg::*;

    logic        r_in_valid;
    logic        r_in_flush;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [31:0] r_out_code;
    logic [2:0]  r_out_count;
    t_rkind      r_out_kind;
    logic        r_out_zone;
    logic        w_out_ready;
    logic        w_in_fire;
    t_result     w_result;

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_in_fire   = r_in_valid && w_out_ready;
    assign o_s_tready  = !r_in_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_flush <= i_s_tuser[0];
            r_in_byte  <= i_s_tdata;
        end
    end

    gsf_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_in_fire),
        .i_flush  (r_in_flush),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_in_fire && w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_result.valid) begin
            r_out_code  <= w_result.code;
            r_out_count <= w_result.count;
            r_out_kind  <= w_result.kind;
            r_out_zone  <= w_result.zone;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000, r_out_count, r_out_code};
    assign o_m_tuser  = {r_out_zone, r_out_kind};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count >= 3'd1 && r_out_count <= 3'd4))
        else $error("byte count out of range");

    a_zone_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zone) |-> (r_out_kind == RK_TWO))
        else $error("zone flag on a result that is not a two-byte code");

    a_kind_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == RK_FOUR) |-> (r_out_count == 3'd4))
        else $error("four-byte code with wrong byte count");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_in_flush && !w_result.valid) |=> !r_out_valid)
        else $error("flush with nothing pending produced a result");

endmodule

`default_nettype wire

// File: rtl/core/gsf_classify.sv
`default_nettype none

module gsf_classify (
    input  wire logic [7:0]   i_byte,
    output gsf_pkg::t_cls     o_cls
);
    import gsf_pkg::*;

    always_comb begin
        if (i_byte == 8'hFF) begin
            o_cls = CLS_INVALID;
        end else if (i_byte >= 8'h81) begin
            o_cls = CLS_LEAD;
        end else if (i_byte == 8'h80) begin
            o_cls = CLS_TRAIL;
        end else if (i_byte == 8'h7F || i_byte < 8'h20) begin
            o_cls = CLS_CONTROL;
        end else if (i_byte >= 8'h40) begin
            o_cls = CLS_TRAIL;
        end else if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            o_cls = CLS_DIGIT;
        end else begin
            o_cls = CLS_GRAPHIC;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gsf_step.sv
`default_nettype none

module gsf_step (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_fire,
    input  wire logic         i_flush,
    input  wire logic [7:0]   i_byte,
    output gsf_pkg::t_result  o_result
);
    import gsf_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [23:0] r_pending;
    logic [23:0] n_pending;
    t_cls        w_cls;
    logic [31:0] w_joined;
    logic        w_zone;

    gsf_classify u_classify (
        .i_byte (i_byte),
        .o_cls  (w_cls)
    );

    assign w_joined = {r_pending, i_byte};
    assign w_zone   = (r_pending[7:0] >= ZONE_MIN) && (i_byte >= ZONE_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EMPTY;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pending <= n_pending;
        end
    end

    always_comb begin
        n_phase        = PH_EMPTY;
        n_pending      = r_pending;
        o_result.valid = 1'b1;
        o_result.kind  = RK_MALFORMED;
        o_result.code  = {8'h00, r_pending};
        o_result.count = {1'b0, r_phase};
        o_result.zone  = 1'b0;
        if (i_flush) begin
            // flush pending bytes; nothing pending gives no result
            o_result.valid = (r_phase != PH_EMPTY);
        end else begin
            unique case (r_phase)
                PH_EMPTY: begin
                    o_result.code  = {24'h000000, i_byte};
                    o_result.count = 3'd1;
                    if (w_cls == CLS_LEAD) begin
                        o_result.valid = 1'b0;
                        n_pending      = {16'h0000, i_byte};
                        n_phase        = PH_ONE;
                    end else if (w_cls != CLS_INVALID) begin
                        o_result.kind = RK_SINGLE;
                    end
                end
                PH_ONE: begin
                    o_result.code  = {16'h0000, w_joined[15:0]};
                    o_result.count = 3'd2;
                    if (w_cls == CLS_TRAIL || w_cls == CLS_LEAD) begin
                        o_result.kind = RK_TWO;
                        o_result.zone = w_zone;
                    end else if (w_cls == CLS_DIGIT) begin
                        o_result.valid = 1'b0;
                        n_pending      = {8'h00, w_joined[15:0]};
                        n_phase        = PH_TWO;
                    end
                end
                PH_TWO: begin
                    o_result.code  = {8'h00, w_joined[23:0]};
                    o_result.count = 3'd3;
                    if (w_cls == CLS_LEAD) begin
                        o_result.valid = 1'b0;
                        n_pending      = w_joined[23:0];
                        n_phase        = PH_THREE;
                    end
                end
                PH_THREE: begin
                    o_result.code  = w_joined;
                    o_result.count = 3'd4;
                    if (w_cls == CLS_DIGIT) begin
                        o_result.kind = RK_FOUR;
                    end
                end
                default: begin
                    o_result.valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    import gsf_pkg::*;

    typedef struct {
        logic       flush;
        logic [7:0] value;
    } t_stream_byte;

    typedef struct {
        t_rkind      kind;
        logic [31:0] code;
        logic [2:0]  count;
        logic        zone;
    } t_code_unit;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] byte_value
    logic [0:0]  i_s_tuser  = 1'b0;    // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;            // [31:0] code_bytes, [34:32] byte_count, [39:35] zero
    logic [2:0]  o_m_tuser;            // [1:0] result_kind, [2] gb2312_zone

    gb18030_sequence_framer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    t_stream_byte byte_stream[$];
    t_code_unit   due_units[$];

    // framer state mirror
    t_phase      framer_phase = PH_EMPTY;
    logic [23:0] held_bytes   = 24'h0;

    int          errors       = 0;
    int          total_bytes  = 0;
    int          n_accepted   = 0;
    int          n_flushes    = 0;
    int          n_units      = 0;
    int          n_zone       = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};
    int          send_gap     = 0;
    int          recv_stall   = 0;
    bit          send_steady  = 1'b0;
    bit          recv_steady  = 1'b0;
    logic        hold_off     = 1'b0;
    t_stream_byte next_byte;
    t_code_unit   seen;
    t_code_unit   want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("TIMEOUT: %0d of %0d requests taken, %0d results outstanding",
                 n_accepted, total_bytes, due_units.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_cls byte_class(input logic [7:0] b);
        if (b == 8'hFF) return CLS_INVALID;
        if (b >= 8'h81) return CLS_LEAD;
        if (b == 8'h80) return CLS_TRAIL;
        if (b == 8'h7F || b < 8'h20) return CLS_CONTROL;
        if (b >= 8'h40) return CLS_TRAIL;
        if (b >= 8'h30 && b <= 8'h39) return CLS_DIGIT;
        return CLS_GRAPHIC;
    endfunction

    function automatic void queue_unit(input t_rkind kind, input logic [31:0] code,
                                       input logic [2:0] count, input logic zone);
        t_code_unit u;
        u.kind  = kind;
        u.code  = code;
        u.count = count;
        u.zone  = zone;
        due_units.push_back(u);
    endfunction

    // Advance the framer mirror by one request and queue any code unit it closes.
    function automatic void frame_byte(input logic flush, input logic [7:0] b);
        t_cls        cls;
        logic [31:0] joined;
        cls    = byte_class(b);
        joined = {held_bytes, b};
        if (flush) begin
            if (framer_phase != PH_EMPTY)
                queue_unit(RK_MALFORMED, {8'h00, held_bytes}, {1'b0, framer_phase}, 1'b0);
            framer_phase = PH_EMPTY;
            return;
        end
        case (framer_phase)
            PH_EMPTY: begin
                if (cls == CLS_LEAD) begin
                    held_bytes   = {16'h0, b};
                    framer_phase = PH_ONE;
                end else if (cls == CLS_INVALID) begin
                    queue_unit(RK_MALFORMED, {24'h0, b}, 3'd1, 1'b0);
                end else begin
                    queue_unit(RK_SINGLE, {24'h0, b}, 3'd1, 1'b0);
                end
            end
            PH_ONE: begin
                framer_phase = PH_EMPTY;
                if (cls == CLS_TRAIL || cls == CLS_LEAD) begin
                    queue_unit(RK_TWO, {16'h0, joined[15:0]}, 3'd2,
                               held_bytes[7:0] >= ZONE_MIN && b >= ZONE_MIN);
                end else if (cls == CLS_DIGIT) begin
                    held_bytes   = {8'h0, joined[15:0]};
                    framer_phase = PH_TWO;
                end else begin
                    queue_unit(RK_MALFORMED, {16'h0, joined[15:0]}, 3'd2, 1'b0);
                end
            end
            PH_TWO: begin
                framer_phase = PH_EMPTY;
                if (cls == CLS_LEAD) begin
                    held_bytes   = joined[23:0];
                    framer_phase = PH_THREE;
                end else begin
                    queue_unit(RK_MALFORMED, {8'h0, joined[23:0]}, 3'd3, 1'b0);
                end
            end
            default: begin
                framer_phase = PH_EMPTY;
                if (cls == CLS_DIGIT) queue_unit(RK_FOUR, joined, 3'd4, 1'b0);
                else queue_unit(RK_MALFORMED, joined, 3'd4, 1'b0);
            end
        endcase
    endfunction

    function automatic void push_data(input logic [7:0] b);
        t_stream_byte s;
        s.flush = 1'b0;
        s.value = b;
        byte_stream.push_back(s);
    endfunction

    function automatic void push_flush();
        t_stream_byte s;
        s.flush = 1'b1;
        s.value = 8'($urandom_range(0, 255));
        byte_stream.push_back(s);
    endfunction

    function automatic logic [7:0] lead_byte();
        return 8'($urandom_range(8'h81, 8'hFE));
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    // trail range is 0x40-0x7E, 0x80 and every lead byte
    function automatic logic [7:0] trail_byte();
        logic [7:0] t;
        t = 8'($urandom_range(8'h40, 8'hFE));
        if (t == 8'h7F) t = 8'h80;
        return t;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // Sender: hold a request until taken, then wait out a drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   = 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                frame_byte(i_s_tuser[0], i_s_tdata);
                n_accepted++;
                if (i_s_tuser[0]) n_flushes++;
                send_gap = send_steady ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
                next_byte = byte_stream.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= next_byte.value;
                i_s_tuser  <= next_byte.flush;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest expectation, then stall a while.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                seen.kind  = t_rkind'(o_m_tuser[1:0]);
                seen.zone  = o_m_tuser[2];
                seen.code  = o_m_tdata[31:0];
                seen.count = o_m_tdata[34:32];
                if (o_m_tdata[39:35] !== 5'd0)
                    log_mismatch($sformatf("tdata pad bits %b not zero", o_m_tdata[39:35]));
                if (due_units.size() == 0) begin
                    log_mismatch($sformatf("unexpected result kind %0d code %h count %0d",
                                           o_m_tuser[1:0], seen.code, seen.count));
                end else begin
                    want = due_units.pop_front();
                    n_units++;
                    kind_seen[want.kind]++;
                    if (want.zone) n_zone++;
                    if (o_m_tuser[1:0] !== want.kind)
                        log_mismatch($sformatf("result %0d: kind %0d, want %0d",
                                               n_units, o_m_tuser[1:0], want.kind));
                    if (seen.code !== want.code)
                        log_mismatch($sformatf("result %0d: code %h, want %h",
                                               n_units, seen.code, want.code));
                    if (seen.count !== want.count)
                        log_mismatch($sformatf("result %0d: count %0d, want %0d",
                                               n_units, seen.count, want.count));
                    if (seen.zone !== want.zone)
                        log_mismatch($sformatf("result %0d: zone %b, want %b",
                                               n_units, seen.zone, want.zone));
                end
                recv_stall = recv_steady ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
            end
            if (hold_off) begin
                i_m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Back-pressure: block the output long enough to fill the framer and stall its input.
    initial begin
        wait (n_accepted >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        // single bytes of every class but lead, including 0xFF alone
        push_data(8'h00); push_data(8'h7F); push_data(8'h20); push_data(8'h3F);
        push_data(8'h30); push_data(8'h39); push_data(8'h40); push_data(8'h80);
        push_data(8'hFF);
        // two-byte codes: lowest pair, and lead as trail inside the GB2312 zone
        push_data(8'h81); push_data(8'h40);
        push_data(8'hA1); push_data(8'hFE);
        // four-byte codes at both ends of the ranges
        push_data(8'h81); push_data(8'h30); push_data(8'h81); push_data(8'h30);
        push_data(8'hFE); push_data(8'h39); push_data(8'hFE); push_data(8'h39);
        // graphic after a lead byte
        push_data(8'h81); push_data(8'h20);
        // flush with three bytes held, then flush with nothing held
        push_data(8'hFE); push_data(8'h30); push_data(8'hA1);
        push_flush();
        push_flush();

        while (byte_stream.size() < 1050) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: push_data(8'($urandom_range(0, 128)));
                6, 7, 8, 9: begin
                    push_data(lead_byte());
                    push_data(trail_byte());
                end
                10, 11, 12, 13: begin
                    push_data(lead_byte());
                    push_data(digit_byte());
                    push_data(lead_byte());
                    push_data(digit_byte());
                end
                14: push_data(8'($urandom_range(0, 255)));
                15: begin
                    push_data(lead_byte());
                    push_data(8'($urandom_range(0, 255)));
                end
                16: begin
                    push_data(lead_byte());
                    push_data(digit_byte());
                    push_data(8'($urandom_range(0, 255)));
                end
                17: begin
                    push_data(lead_byte());
                    push_data(digit_byte());
                    push_data(lead_byte());
                    push_data(8'($urandom_range(0, 255)));
                end
                18: begin
                    // cut a sequence short and flush it
                    push_data(lead_byte());
                    if ($urandom_range(0, 1)) push_data(digit_byte());
                    if ($urandom_range(0, 1)) push_data(lead_byte());
                    push_flush();
                end
                default: push_flush();
            endcase
        end
        total_bytes = byte_stream.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == total_bytes);
        wait (due_units.size() == 0);
        repeat (8) @(posedge i_clk);

        $display("Streamed %0d requests (%0d flushes) and checked %0d results.",
                 total_bytes, n_flushes, n_units);
        $display("Results: %0d single, %0d two-byte (%0d GB2312), %0d four-byte, %0d malformed.",
                 kind_seen[RK_SINGLE], kind_seen[RK_TWO], n_zone, kind_seen[RK_FOUR],
                 kind_seen[RK_MALFORMED]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
